// ===== rtl/adt_pkg.sv =====
// package: shared types and constants for the acceleration delta trigger
`default_nettype none

package adt_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned SAMPLE_W  = 20;
  localparam int unsigned DELTA_W   = 21;
  localparam int unsigned AVG_W     = 21;
  localparam int unsigned LEVEL_W   = 21;
  localparam int unsigned SENS_W    = 8;
  localparam int unsigned AXES      = 3;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  // status bit that flags fresh xyz data
  localparam int unsigned NEW_DATA_BIT = 3;

  // divide by 16 normally, by 64 in fifo mode
  localparam int unsigned NORMAL_SHIFT = 4;
  localparam int unsigned FIFO_SHIFT   = 6;

  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIG_ENDIAN    = 2'd0,
    REG_SENSITIVITY   = 2'd1,
    REG_FIFO_ENABLED  = 2'd2,
    REG_TRIGGER_LEVEL = 2'd3
  } cfg_reg_t;

  // settings the scaling path needs
  typedef struct packed {
    logic              big_endian;
    logic [SENS_W-1:0] sensitivity;
    logic              fifo_enabled;
  } scale_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/adt_scale.sv =====
// one axis: byte pair assembly, sensitivity scaling and truncating divide
`default_nettype none

module adt_scale (
  input  wire logic [adt_pkg::BYTE_W-1:0]    first_byte,
  input  wire logic [adt_pkg::BYTE_W-1:0]    second_byte,
  input  wire adt_pkg::scale_cfg_t           cfg,
  output logic signed [adt_pkg::SAMPLE_W-1:0] sample
);

  localparam int unsigned PROD_W = adt_pkg::RAW_W + adt_pkg::SENS_W + 1;

  logic signed [adt_pkg::RAW_W-1:0] raw;
  logic signed [adt_pkg::SENS_W:0]  sens_s;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         bias;
  logic signed [PROD_W-1:0]         biased;
  logic signed [PROD_W-1:0]         shifted;

  always_comb begin
    raw    = cfg.big_endian ? {first_byte, second_byte} : {second_byte, first_byte};
    sens_s = signed'({1'b0, cfg.sensitivity});
    prod   = PROD_W'(raw) * PROD_W'(sens_s);
    // negative products get divisor-1 added so the shift truncates toward zero
    if (prod[PROD_W-1]) begin
      bias = cfg.fifo_enabled ? PROD_W'((1 << adt_pkg::FIFO_SHIFT) - 1)
                              : PROD_W'((1 << adt_pkg::NORMAL_SHIFT) - 1);
    end else begin
      bias = '0;
    end
    biased  = prod + bias;
    shifted = cfg.fifo_enabled ? (biased >>> adt_pkg::FIFO_SHIFT)
                               : (biased >>> adt_pkg::NORMAL_SHIFT);
    sample  = shifted[adt_pkg::SAMPLE_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/accel_delta_trigger_unit.sv =====
// top level: acceleration scaling with running-average delta trigger
`default_nettype none

// Takes one beat per clock unless stalled: a status byte and six raw bytes (x,
// y, z pairs). Beats whose status bit 3 is clear are taken and dropped without
// touching the averages. Every other beat gives one result beat, through the
// input and result registers: three scaled samples, their deltas from the
// per-axis running averages and a trigger flag set when any delta is above
// trigger_level (signed). The whole job, multiply, divide and average update,
// is one registered pass from the input register to the result register, so a
// new beat can enter on every cycle without a stall; the running averages are
// the only state carried from beat to beat. After reset the averages are zero,
// and whenever all three are zero they are first loaded with the current
// samples. Registers are written through cfg_write / cfg_index / cfg_data and
// should only change while no beat is in flight.

module accel_delta_trigger_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // data_status[7:0], raw_byte_0 .. raw_byte_5 in following bytes
  input  wire logic [adt_pkg::IN_DATA_W-1:0]      s_tdata,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // accel_x[19:0], accel_y[39:20], accel_z[59:40], delta_x[80:60],
  // delta_y[101:81], delta_z[122:102], trigger[123], zeros above
  output logic [adt_pkg::OUT_DATA_W-1:0]          m_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic                               cfg_write,
  input  wire logic [adt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [adt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned SW = adt_pkg::SAMPLE_W;
  localparam int unsigned DW = adt_pkg::DELTA_W;
  localparam int unsigned AW = adt_pkg::AVG_W;
  localparam int unsigned BW = adt_pkg::BYTE_W;

  // configuration registers
  adt_pkg::scale_cfg_t                  scale_cfg;
  logic signed [adt_pkg::LEVEL_W-1:0]   trigger_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_cfg.big_endian   <= 1'b0;
      scale_cfg.sensitivity  <= adt_pkg::SENS_RESET;
      scale_cfg.fifo_enabled <= 1'b0;
      trigger_level          <= '0;
    end else if (cfg_write) begin
      case (adt_pkg::cfg_reg_t'(cfg_index))
        adt_pkg::REG_BIG_ENDIAN:    scale_cfg.big_endian   <= cfg_data[0];
        adt_pkg::REG_SENSITIVITY:   scale_cfg.sensitivity  <= cfg_data[adt_pkg::SENS_W-1:0];
        adt_pkg::REG_FIFO_ENABLED:  scale_cfg.fifo_enabled <= cfg_data[0];
        adt_pkg::REG_TRIGGER_LEVEL: trigger_level <= signed'(cfg_data[adt_pkg::LEVEL_W-1:0]);
        default: ;
      endcase
    end
  end

  // handshake: result register frees when empty or being taken
  logic out_adv;
  logic s1_valid;
  logic [adt_pkg::IN_DATA_W-1:0] s1_data;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_adv;

  // input register, only beats with fresh data become valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid && s_tdata[adt_pkg::NEW_DATA_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_data <= s_tdata;
    end
  end

  // per-axis scaling
  logic signed [SW-1:0] sample [adt_pkg::AXES];

  for (genvar i = 0; i < adt_pkg::AXES; i++) begin : g_axis
    adt_scale u_scale (
      .first_byte  (s1_data[(2*i+2)*BW-1 -: BW]),
      .second_byte (s1_data[(2*i+3)*BW-1 -: BW]),
      .cfg         (scale_cfg),
      .sample      (sample[i])
    );
  end

  // running averages and delta / trigger logic
  logic signed [AW-1:0] avg      [adt_pkg::AXES];
  logic signed [AW-1:0] avg_next [adt_pkg::AXES];
  logic signed [AW-1:0] base     [adt_pkg::AXES];
  logic signed [DW-1:0] delta    [adt_pkg::AXES];
  logic signed [AW:0]   sum      [adt_pkg::AXES];
  logic signed [AW:0]   sum_b    [adt_pkg::AXES];
  logic                 all_zero;
  logic                 trig;

  always_comb begin
    all_zero = (avg[0] == '0) && (avg[1] == '0) && (avg[2] == '0);
    trig     = 1'b0;
    for (int i = 0; i < adt_pkg::AXES; i++) begin
      // averages all zero: seed with the current sample
      base[i]  = all_zero ? AW'(sample[i]) : avg[i];
      delta[i] = DW'(sample[i]) - DW'(base[i]);
      sum[i]   = (AW+1)'(base[i]) + (AW+1)'(sample[i]);
      // halve toward zero
      sum_b[i] = sum[i] + (AW+1)'(sum[i][AW]);
      avg_next[i] = AW'(sum_b[i] >>> 1);
      if (delta[i] > DW'(trigger_level)) begin
        trig = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < adt_pkg::AXES; i++) begin
        avg[i] <= '0;
      end
    end else if (out_adv && s1_valid) begin
      for (int i = 0; i < adt_pkg::AXES; i++) begin
        avg[i] <= avg_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      m_tdata <= {4'b0000, trig, delta[2], delta[1], delta[0],
                  sample[2], sample[1], sample[0]};
    end
  end

endmodule

`default_nettype wire
